### src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// shared widths, action codes and pipeline control type for the 4x4 transform
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DATA_W = 32;            // one Q-format component
    localparam int PROD_W = 2 * DATA_W;    // full product
    localparam int PAIR_W = PROD_W + 1;    // sum of two products
    localparam int SUM_W  = PROD_W + 2;    // sum of four products
    localparam int DIM    = 4;             // rows and columns
    localparam int COEF_N = DIM * DIM;     // coefficients in the store
    localparam int IDX_W  = 4;             // coefficient index width

    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSFORM = 1'b1;

    // per-stage load enables, stage 1 is the product stage
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctrl;

endpackage

### src/matrix_vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4: signed fixed-point 4x4 matrix times vector
// pipeline: each accepted transform word passes the stages below in order, each stage registered
// throughput: one word per cycle while the output does not stall; stages are products, pairs, sum, shift/clamp
// reset: synchronous active low, clears the matrix to zero and empties the pipe
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic [mvt_pkg::IDX_W-1:0]         i_coef_index,
    input  logic signed [mvt_pkg::DATA_W-1:0] i_coef_value,
    input  logic signed [mvt_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [mvt_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [mvt_pkg::DATA_W-1:0] i_vec_z,
    input  logic signed [mvt_pkg::DATA_W-1:0] i_vec_w,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [mvt_pkg::DATA_W-1:0] o_out_x,
    output logic signed [mvt_pkg::DATA_W-1:0] o_out_y,
    output logic signed [mvt_pkg::DATA_W-1:0] o_out_z,
    output logic signed [mvt_pkg::DATA_W-1:0] o_out_w,
    output logic                              o_clipped
);

    // column-major coefficient store, index is column*4+row
    logic signed [mvt_pkg::DATA_W-1:0] r_coef [mvt_pkg::COEF_N];

    // one valid bit per pipeline stage, stage 4 is the output register
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_accept;

    mvt_pkg::t_pipe_ctrl w_ctrl;

    logic signed [mvt_pkg::DATA_W-1:0] w_vec [mvt_pkg::DIM];
    logic signed [mvt_pkg::DATA_W-1:0] w_lane_coef [mvt_pkg::DIM][mvt_pkg::DIM];
    logic signed [mvt_pkg::DATA_W-1:0] w_lane_out [mvt_pkg::DIM];
    logic        [mvt_pkg::DIM-1:0]    w_lane_clip;

    // ready ripples back from the output; a stage loads when it is empty or
    // its contents move on in the same cycle, so a stall never drops a word
    assign w_rdy4   = !r_v4 || !i_stall;
    assign w_rdy3   = !r_v3 || w_rdy4;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign o_stall  = !w_rdy1;
    assign w_accept = i_valid && !o_stall;

    assign w_ctrl.en1 = w_rdy1;
    assign w_ctrl.en2 = w_rdy2;
    assign w_ctrl.en3 = w_rdy3;
    assign w_ctrl.en4 = w_rdy4;

    // coefficient writes land at acceptance; the products of a transform are
    // taken in the same cycle it is accepted, so later writes never reach
    // transforms already in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mvt_pkg::COEF_N; k++) begin
                r_coef[k] <= '0;
            end
        end else if (w_accept && i_action == mvt_pkg::ACT_WRITE) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    // valid bits; write words never enter the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_accept && i_action == mvt_pkg::ACT_TRANSFORM;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    assign w_vec[0] = i_vec_x;
    assign w_vec[1] = i_vec_y;
    assign w_vec[2] = i_vec_z;
    assign w_vec[3] = i_vec_w;

    // one lane per output row, each row reads its four coefficients at fixed places
    for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_lane
        for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_tap
            assign w_lane_coef[r][c] = r_coef[c * mvt_pkg::DIM + r];
        end

        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_coef  (w_lane_coef[r]),
            .i_vec   (w_vec),
            .o_value (w_lane_out[r]),
            .o_clip  (w_lane_clip[r])
        );
    end

    // the lane output registers form the output stage
    assign o_valid   = r_v4;
    assign o_out_x   = w_lane_out[0];
    assign o_out_y   = w_lane_out[1];
    assign o_out_z   = w_lane_out[2];
    assign o_out_w   = w_lane_out[3];
    assign o_clipped = |w_lane_clip;

`ifndef SYNTHESIS
    // an empty first stage always takes a word
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with an empty product stage");

    // a word in the sum stage moves into an empty output stage
    a_sum_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_v4 |=> r_v4)
        else $error("word lost between sum and output stage");

    // an accepted write is visible in the store on the next cycle
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_action == mvt_pkg::ACT_WRITE
        |=> r_coef[$past(i_coef_index)] == $past(i_coef_value))
        else $error("coefficient write not stored");

    // reset empties the output stage
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

### src/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane
// one output row: four products, two-level adder tree, shift and saturate
// ----------------------------------------------------------------------------
module mvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  mvt_pkg::t_pipe_ctrl                 i_ctrl,
    input  logic signed [mvt_pkg::DATA_W-1:0]   i_coef [mvt_pkg::DIM],
    input  logic signed [mvt_pkg::DATA_W-1:0]   i_vec  [mvt_pkg::DIM],
    output logic signed [mvt_pkg::DATA_W-1:0]   o_value,
    output logic                                o_clip
);

    logic signed [mvt_pkg::PROD_W-1:0] r_prod [mvt_pkg::DIM];
    logic signed [mvt_pkg::PAIR_W-1:0] r_pair [2];
    logic signed [mvt_pkg::SUM_W-1:0]  r_sum;
    logic signed [mvt_pkg::SUM_W-1:0]  w_shift;
    logic        [mvt_pkg::SUM_W-mvt_pkg::DATA_W:0] w_hi;
    logic signed [mvt_pkg::DATA_W-1:0] n_value;
    logic                              n_clip;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                r_prod[c] <= i_coef[c] * i_vec[c];
            end
        end
    end

    // stage 2: pair sums
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_pair[0] <= mvt_pkg::PAIR_W'(r_prod[0]) + mvt_pkg::PAIR_W'(r_prod[1]);
            r_pair[1] <= mvt_pkg::PAIR_W'(r_prod[2]) + mvt_pkg::PAIR_W'(r_prod[3]);
        end
    end

    // stage 3: full sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_sum <= mvt_pkg::SUM_W'(r_pair[0]) + mvt_pkg::SUM_W'(r_pair[1]);
        end
    end

    // stage 4: floor shift, then clamp to 32 bits
    assign w_shift = r_sum >>> FRAC_BITS;
    assign w_hi    = w_shift[mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            n_value = w_shift[mvt_pkg::DATA_W-1:0];
            n_clip  = 1'b0;
        end else if (w_shift[mvt_pkg::SUM_W-1]) begin
            n_value = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};
            n_clip  = 1'b1;
        end else begin
            n_value = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
            n_clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en4) begin
            o_value <= n_value;
            o_clip  <= n_clip;
        end
    end

endmodule

### verif/matrix_vector_transform_4x4_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_tb
// self-checking bench for the 4x4 fixed-point matrix times vector block:
// coefficient writes and transforms go through the input channel, a local
// predictor computes each expected result exactly, a monitor compares every
// result word lane by lane; random gaps, output stalls and a long hold-off
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_tb;

    localparam int FRAC_BITS    = 16;
    localparam int CLK_HALF     = 5;       // 10 ns period
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;  // far above the slowest clean run
    localparam int GAP_PCT      = 38;      // idle / stall chance per cycle
    localparam int HOLD_CYCLES  = 300;     // long output hold-off
    localparam int DRAIN_CYCLES = 12;      // pipe is 4 deep, plenty of margin
    localparam int RANDOM_WORDS = 120;

    localparam logic signed [mvt_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [mvt_pkg::DATA_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [mvt_pkg::DATA_W-1:0] Q_ONE = 32'sh00010000;

    // saturation bounds at the width of the full four-product sum
    localparam logic signed [mvt_pkg::SUM_W-1:0] LANE_MAX = mvt_pkg::SUM_W'(Q_MAX);
    localparam logic signed [mvt_pkg::SUM_W-1:0] LANE_MIN = mvt_pkg::SUM_W'(Q_MIN);

    // lane 0 is x, lane 3 is w
    typedef struct packed {
        logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] lane;
        logic                                         clipped;
    } t_lane_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_action;
    logic [mvt_pkg::IDX_W-1:0]         i_coef_index;
    logic signed [mvt_pkg::DATA_W-1:0] i_coef_value;
    logic signed [mvt_pkg::DATA_W-1:0] i_vec_x;
    logic signed [mvt_pkg::DATA_W-1:0] i_vec_y;
    logic signed [mvt_pkg::DATA_W-1:0] i_vec_z;
    logic signed [mvt_pkg::DATA_W-1:0] i_vec_w;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [mvt_pkg::DATA_W-1:0] o_out_x;
    logic signed [mvt_pkg::DATA_W-1:0] o_out_y;
    logic signed [mvt_pkg::DATA_W-1:0] o_out_z;
    logic signed [mvt_pkg::DATA_W-1:0] o_out_w;
    logic                              o_clipped;

    // shadow copy of the coefficient store, updated when a write word is taken
    logic signed [mvt_pkg::DATA_W-1:0] coef_mem [mvt_pkg::COEF_N];
    // transform results still owed by the block, oldest first
    t_lane_result                      pending_results [$];

    int    errors;
    int    cycle_count;
    int    hold_left;
    bit    no_gaps;     // both sides run without idling
    bit    hold_req;    // asks the output side for a long hold-off
    string lane_name [mvt_pkg::DIM] = '{"out_x", "out_y", "out_z", "out_w"};

    matrix_vector_transform_4x4 #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_vec_w      (i_vec_w),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_w      (o_out_w),
        .o_clipped    (o_clipped)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix_vector_transform_4x4 verification failed");
            $finish;
        end
    end

    // exact matrix times vector: 64-bit products summed at full width,
    // arithmetic shift (floor), then clamp each lane to 32 bits
    function automatic t_lane_result predict_transform(
        input logic signed [mvt_pkg::DATA_W-1:0] x,
        input logic signed [mvt_pkg::DATA_W-1:0] y,
        input logic signed [mvt_pkg::DATA_W-1:0] z,
        input logic signed [mvt_pkg::DATA_W-1:0] w
    );
        t_lane_result                      r;
        logic signed [mvt_pkg::DATA_W-1:0] comp [mvt_pkg::DIM];
        logic signed [mvt_pkg::PROD_W-1:0] prod;
        logic signed [mvt_pkg::SUM_W-1:0]  acc;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        comp[3] = w;
        r = '0;
        for (int row = 0; row < mvt_pkg::DIM; row++) begin
            acc = '0;
            for (int col = 0; col < mvt_pkg::DIM; col++) begin
                prod = coef_mem[col * mvt_pkg::DIM + row] * comp[col];
                acc  = acc + prod;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > LANE_MAX) begin
                r.lane[row] = Q_MAX;
                r.clipped   = 1'b1;
            end else if (acc < LANE_MIN) begin
                r.lane[row] = Q_MIN;
                r.clipped   = 1'b1;
            end else begin
                r.lane[row] = acc[mvt_pkg::DATA_W-1:0];
            end
        end
        return r;
    endfunction

    // value mix: extremes, zero, small magnitudes that stay in range, raw noise
    function automatic logic signed [mvt_pkg::DATA_W-1:0] rand_q16();
        int v;
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4: begin
                v = $urandom_range(0, 4 << FRAC_BITS);
                return ($urandom_range(1) != 0) ? -v : v;
            end
            default: return $urandom;
        endcase
    endfunction

    // offer one word and hold it until taken; leaves time at a falling edge
    task automatic send_word(
        input logic                              act,
        input logic [mvt_pkg::IDX_W-1:0]         idx,
        input logic signed [mvt_pkg::DATA_W-1:0] cval,
        input logic signed [mvt_pkg::DATA_W-1:0] x,
        input logic signed [mvt_pkg::DATA_W-1:0] y,
        input logic signed [mvt_pkg::DATA_W-1:0] z,
        input logic signed [mvt_pkg::DATA_W-1:0] w
    );
        while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_action     = act;
        i_coef_index = idx;
        i_coef_value = cval;
        i_vec_x      = x;
        i_vec_y      = y;
        i_vec_z      = z;
        i_vec_w      = w;
        do @(posedge i_clk); while (o_stall);
        // word taken at this edge: advance the shadow state in order
        if (act == mvt_pkg::ACT_WRITE)
            coef_mem[idx] = cval;
        else
            pending_results.push_back(predict_transform(x, y, z, w));
        @(negedge i_clk);
    endtask

    // write word: vector fields carry junk the block must ignore
    task automatic write_coef(
        input logic [mvt_pkg::IDX_W-1:0]         idx,
        input logic signed [mvt_pkg::DATA_W-1:0] val
    );
        send_word(mvt_pkg::ACT_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom);
    endtask

    // transform word: coefficient fields carry junk the block must ignore
    task automatic transform(
        input logic signed [mvt_pkg::DATA_W-1:0] x,
        input logic signed [mvt_pkg::DATA_W-1:0] y,
        input logic signed [mvt_pkg::DATA_W-1:0] z,
        input logic signed [mvt_pkg::DATA_W-1:0] w
    );
        send_word(mvt_pkg::ACT_TRANSFORM, mvt_pkg::IDX_W'($urandom), $urandom, x, y, z, w);
    endtask

    // one random word: mostly transforms, now and then a single coefficient
    task automatic random_word();
        if ($urandom_range(9) == 0)
            write_coef(mvt_pkg::IDX_W'($urandom_range(mvt_pkg::COEF_N - 1)), rand_q16());
        else
            transform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endtask

    // output side: random stalls, long hold-off on request, none in a clean stretch
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = !no_gaps && ($urandom_range(99) < GAP_PCT);
        end
    end

    // result monitor: every taken result word against the oldest prediction
    always @(posedge i_clk) begin
        t_lane_result got;
        t_lane_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.lane    = {o_out_w, o_out_z, o_out_y, o_out_x};
            got.clipped = o_clipped;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word x=%h y=%h z=%h w=%h clipped=%b",
                         $time, o_out_x, o_out_y, o_out_z, o_out_w, o_clipped);
            end else begin
                want = pending_results.pop_front();
                for (int i = 0; i < mvt_pkg::DIM; i++) begin
                    if (got.lane[i] !== want.lane[i]) begin
                        errors++;
                        $display("%0t: %s mismatch expected %h actual %h",
                                 $time, lane_name[i], want.lane[i], got.lane[i]);
                    end
                end
                if (got.clipped !== want.clipped) begin
                    errors++;
                    $display("%0t: clipped mismatch expected %b actual %b",
                             $time, want.clipped, got.clipped);
                end
            end
        end
    end

    // matrix is all zero after reset: extreme vectors must give zero
    task automatic test_cleared_matrix();
        transform(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        transform(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    endtask

    // identity matrix passes extreme components straight through
    task automatic test_identity();
        for (int i = 0; i < mvt_pkg::DIM; i++)
            write_coef(mvt_pkg::IDX_W'(i * mvt_pkg::DIM + i), Q_ONE);
        transform(Q_MAX, Q_MIN, '0, Q_ONE);
        transform(Q_MIN, Q_MAX, -Q_ONE, 32'sd1);
        transform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endtask

    // huge coefficient drives lane x past both rails, other lanes stay exact
    task automatic test_saturation();
        write_coef('0, Q_MAX);
        transform(Q_MAX, Q_MAX, '0, Q_MIN);
        transform(Q_MIN, Q_MIN, Q_ONE, '0);
    endtask

    // shift rounds toward minus infinity: -1 lsb stays -1, +1 lsb drops to 0
    task automatic test_floor_shift();
        write_coef('0, -32'sd1);
        transform(32'sd1, '0, '0, '0);
        transform(-32'sd1, '0, '0, '0);
    endtask

    // random matrices and vector bursts
    task automatic test_random_mix();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            // full matrix reload, then a stream of vectors through it
            if ($urandom_range(3) == 0) begin
                for (int i = 0; i < mvt_pkg::COEF_N; i++)
                    write_coef(mvt_pkg::IDX_W'(i), rand_q16());
                sent += mvt_pkg::COEF_N;
            end
            burst = $urandom_range(4, 24);
            repeat (burst) random_word();
            sent += burst;
        end
    endtask

    // clean stretch: no idle cycles and no stalls on either side
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        repeat (80) random_word();
        no_gaps = 1'b0;
    endtask

    // output held off for a long time while input keeps offering words,
    // so the pipe fills and input stall must rise
    task automatic test_output_holdoff();
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (40) transform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        no_gaps  = 1'b0;
    endtask

    initial begin
        errors       = 0;
        cycle_count  = 0;
        hold_left    = 0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_action     = mvt_pkg::ACT_WRITE;
        i_coef_index = '0;
        i_coef_value = '0;
        i_vec_x      = '0;
        i_vec_y      = '0;
        i_vec_z      = '0;
        i_vec_w      = '0;
        for (int i = 0; i < mvt_pkg::COEF_N; i++)
            coef_mem[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cleared_matrix();
        test_identity();
        test_saturation();
        test_floor_shift();
        test_random_mix();
        test_back_to_back();
        test_output_holdoff();
        test_random_mix();

        // let the pipe empty, then a few spare cycles for stray words
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("matrix_vector_transform_4x4 verification clean");
        end else begin
            $display("matrix_vector_transform_4x4 verification failed");
        end
        $finish;
    end

endmodule

### files.f
src/mvt_pkg.sv
src/mvt_lane.sv
src/matrix_vector_transform_4x4.sv
verif/matrix_vector_transform_4x4_tb.sv
